// ===== sv/tpsp_pkg.sv =====
// Package for the three-phase sine PWM: register codes, reset values, sine ROM builder.
package tpsp_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SINE_AMPLITUDE    = 3'd0,
      CSR_CARRIER_AMPLITUDE = 3'd1,
      CSR_CARRIER_STEP      = 3'd2,
      CSR_PHASE_SPACING     = 3'd3,
      CSR_LOW_ADC_THRESHOLD = 3'd4,
      CSR_LOW_SINE_STEP     = 3'd5,
      CSR_STEP_PER_COUNT    = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;

   // request kinds carried in tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ADC  = 1'b1;

   localparam logic [14:0] SINE_AMPLITUDE_RESET    = 15'd29491;
   localparam logic [14:0] CARRIER_AMPLITUDE_RESET = 15'd32767;
   localparam logic [15:0] CARRIER_STEP_RESET      = 16'd655;
   localparam logic [31:0] PHASE_SPACING_RESET     = 32'd1431655765;
   localparam logic [11:0] LOW_ADC_THRESHOLD_RESET = 12'd200;
   localparam logic [31:0] LOW_SINE_STEP_RESET     = 32'd4295;
   localparam logic [15:0] STEP_PER_COUNT_RESET    = 16'd21;
   localparam logic [31:0] SINE_STEP_RESET         = 32'd2147;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // quarter-wave entry: round(32767 * sin(pi/2 * (idx + 0.5) / 2^bits)), Taylor in Q30
   function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned bits);
      logic [63:0] th;
      logic [63:0] t2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] v;
      th = (((64'(idx) << 1) + 64'd1) * HALF_PI_Q30) >> (bits + 1);
      t2 = (th * th) >> 30;
      h  = Q30_ONE - ((t2 * Q30_ONE) >> 30) / 64'd110;
      h  = Q30_ONE - ((t2 * h) >> 30) / 64'd72;
      h  = Q30_ONE - ((t2 * h) >> 30) / 64'd42;
      h  = Q30_ONE - ((t2 * h) >> 30) / 64'd20;
      h  = Q30_ONE - ((t2 * h) >> 30) / 64'd6;
      s  = (th * h) >> 30;
      v  = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

// ===== sv/three_phase_sine_pwm.sv =====
// Three-phase sine-triangle PWM generator, top level.
// An accepted item is registered in the stage register, then in the output register (rsp_tvalid high).
// Throughput: one item per clock; the stage register and the output register each
// advance whenever the stage after them is empty or drained that cycle.
// Reset (synchronous, active high): phases and last ADC reading go to zero, sine step to
// 2147, configuration registers to defaults, both stages empty; the sine ROM needs no fill.
module three_phase_sine_pwm #(
   parameter int SINE_TABLE_BITS = 8,
   parameter int ADC_BITS        = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tuser fields, low bit up: req_type
   input  logic                                 req_tuser,
   // tdata fields, low bit up: adc_value[ADC_BITS-1:0], zero fill
   input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata fields, low bit up: leg_a_high, leg_b_high, leg_c_high,
   // carrier_level[15:0], step_updated, zero fill
   output logic [tpsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tpsp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpsp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
   localparam int A10_W    = ADC_BITS + 4;

   // ---------------------------------------------------------------
   // Configuration registers; unenforced here, so the user must make writes arrive only while the block is idle
   // ---------------------------------------------------------------
   logic [14:0] sine_amplitude_ff;
   logic [14:0] carrier_amplitude_ff;
   logic [15:0] carrier_step_ff;
   logic [31:0] phase_spacing_ff;
   logic [11:0] low_adc_threshold_ff;
   logic [31:0] low_sine_step_ff;
   logic [15:0] step_per_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_amplitude_ff    <= tpsp_pkg::SINE_AMPLITUDE_RESET;
         carrier_amplitude_ff <= tpsp_pkg::CARRIER_AMPLITUDE_RESET;
         carrier_step_ff      <= tpsp_pkg::CARRIER_STEP_RESET;
         phase_spacing_ff     <= tpsp_pkg::PHASE_SPACING_RESET;
         low_adc_threshold_ff <= tpsp_pkg::LOW_ADC_THRESHOLD_RESET;
         low_sine_step_ff     <= tpsp_pkg::LOW_SINE_STEP_RESET;
         step_per_count_ff    <= tpsp_pkg::STEP_PER_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tpsp_pkg::CSR_SINE_AMPLITUDE:    sine_amplitude_ff    <= csr_data[14:0];
            tpsp_pkg::CSR_CARRIER_AMPLITUDE: carrier_amplitude_ff <= csr_data[14:0];
            tpsp_pkg::CSR_CARRIER_STEP:      carrier_step_ff      <= csr_data[15:0];
            tpsp_pkg::CSR_PHASE_SPACING:     phase_spacing_ff     <= csr_data;
            tpsp_pkg::CSR_LOW_ADC_THRESHOLD: low_adc_threshold_ff <= csr_data[11:0];
            tpsp_pkg::CSR_LOW_SINE_STEP:     low_sine_step_ff     <= csr_data;
            tpsp_pkg::CSR_STEP_PER_COUNT:    step_per_count_ff    <= csr_data[15:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: stage 1 register and output register, each refills on drain
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_open;
   logic s1_open;
   logic req_take;

   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign s1_open    = !s1_valid_ff || out_open;
   assign req_tready = s1_open;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // Stage 0: update phases or sine step as the item is accepted
   // ---------------------------------------------------------------
   logic [31:0]         sine_phase_ff;
   logic [31:0]         sine_phase_in;
   logic [15:0]         carrier_phase_ff;
   logic [15:0]         carrier_phase_in;
   logic [31:0]         sine_step_ff;
   logic [31:0]         sine_step_in;
   logic [ADC_BITS-1:0] last_adc_ff;
   logic [ADC_BITS-1:0] last_adc_in;
   logic                updated_in;

   logic [ADC_BITS-1:0] adc;
   logic [A10_W-1:0]    adc_x10;
   logic [A10_W-1:0]    last_x9;
   logic [A10_W-1:0]    last_x11;
   logic [31:0]         step_product;
   logic                below_threshold;

   assign adc          = req_tdata[ADC_BITS-1:0];
   assign adc_x10      = A10_W'(adc) * A10_W'(10);
   assign last_x9      = A10_W'(last_adc_ff) * A10_W'(9);
   assign last_x11     = A10_W'(last_adc_ff) * A10_W'(11);
   assign step_product = 32'(step_per_count_ff) * 32'(adc);
   assign below_threshold = 16'(adc) < 16'(low_adc_threshold_ff);

   always_comb begin
      sine_phase_in    = sine_phase_ff;
      carrier_phase_in = carrier_phase_ff;
      sine_step_in     = sine_step_ff;
      last_adc_in      = last_adc_ff;
      updated_in       = 1'b0;
      if (req_tuser == tpsp_pkg::REQ_TICK) begin
         // advance both phases; outputs use the new phases
         sine_phase_in    = sine_phase_ff + sine_step_ff;
         carrier_phase_in = carrier_phase_ff + carrier_step_ff;
      end else begin
         priority if (below_threshold) begin
            sine_step_in = low_sine_step_ff;
            last_adc_in  = adc;
            updated_in   = 1'b1;
         end else if ((adc_x10 < last_x9) || (adc_x10 > last_x11)) begin
            // reading moved more than ten percent from the last one taken
            sine_step_in = step_product;
            last_adc_in  = adc;
            updated_in   = 1'b1;
         end else begin
            // reading rejected: hold everything
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_phase_ff    <= '0;
         carrier_phase_ff <= '0;
         sine_step_ff     <= tpsp_pkg::SINE_STEP_RESET;
         last_adc_ff      <= '0;
      end else if (req_take) begin
         sine_phase_ff    <= sine_phase_in;
         carrier_phase_ff <= carrier_phase_in;
         sine_step_ff     <= sine_step_in;
         last_adc_ff      <= last_adc_in;
      end
   end

   // snapshot of the phases this item sees
   logic [31:0] s1_phase_ff;
   logic [15:0] s1_carrier_ff;
   logic        s1_updated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_phase_ff   <= sine_phase_in;
         s1_carrier_ff <= carrier_phase_in;
         s1_updated_ff <= updated_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: triangle carrier, three sines, compares
   // ---------------------------------------------------------------
   logic [14:0] sine_rom [TBL_SIZE];

   for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
      assign sine_rom[g] = tpsp_pkg::sine_entry(g, SINE_TABLE_BITS);
   end

   logic [16:0]        phase_x2;
   logic [17:0]        tri_diff;
   logic [15:0]        tri_mag;
   logic               tri_neg;
   logic [30:0]        carrier_product;
   logic [14:0]        carrier_mag;
   logic               carrier_neg;
   logic signed [16:0] carrier_signed;
   logic [15:0]        carrier_level;

   assign phase_x2 = {s1_carrier_ff, 1'b0};

   always_comb begin
      tri_diff = '0;
      tri_neg  = 1'b0;
      priority if (s1_carrier_ff < 16'd16384) begin
         tri_diff = 18'(phase_x2);
      end else if (s1_carrier_ff < 16'd49152) begin
         if (phase_x2 > 17'd65536) begin
            tri_neg  = 1'b1;
            tri_diff = 18'(phase_x2) - 18'd65536;
         end else begin
            tri_diff = 18'd65536 - 18'(phase_x2);
         end
      end else begin
         tri_neg  = 1'b1;
         tri_diff = 18'd131072 - 18'(phase_x2);
      end
   end

   assign tri_mag         = tri_diff[15:0];
   assign carrier_product = 31'(tri_mag) * 31'(carrier_amplitude_ff);
   assign carrier_mag     = carrier_product[29:15];
   // a zero level carries no sign
   assign carrier_neg     = tri_neg && (carrier_mag != 15'd0);
   assign carrier_signed  = carrier_neg ? -$signed({2'b00, carrier_mag})
                                        : $signed({2'b00, carrier_mag});
   assign carrier_level   = carrier_signed[15:0];

   logic [31:0]                leg_phase [3];
   logic [SINE_TABLE_BITS-1:0] leg_index [3];
   logic [29:0]                leg_product [3];
   logic signed [16:0]         leg_signed [3];
   logic [2:0]                 leg_high;

   assign leg_phase[0] = s1_phase_ff;
   assign leg_phase[1] = s1_phase_ff - phase_spacing_ff;
   assign leg_phase[2] = s1_phase_ff - {phase_spacing_ff[30:0], 1'b0};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // mirror the index in the second and fourth quadrants
         leg_index[k] = leg_phase[k][30] ? ~leg_phase[k][29 -: SINE_TABLE_BITS]
                                         : leg_phase[k][29 -: SINE_TABLE_BITS];
         leg_product[k] = 30'(sine_rom[leg_index[k]]) * 30'(sine_amplitude_ff);
         leg_signed[k]  = leg_phase[k][31] ? -$signed({2'b00, leg_product[k][29:15]})
                                           : $signed({2'b00, leg_product[k][29:15]});
         leg_high[k]    = leg_signed[k] > carrier_signed;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic [tpsp_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [tpsp_pkg::RSP_DATA_W-1:0] rsp_data_in;

   assign rsp_data_in = {4'b0000, s1_updated_ff, carrier_level, leg_high[2], leg_high[1],
                         leg_high[0]};
   assign rsp_tdata   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_adc_holds_phase : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser == tpsp_pkg::REQ_ADC) |=>
         ($stable(sine_phase_ff) && $stable(carrier_phase_ff)))
      else $error("ADC item moved a phase");

   a_tick_no_update : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser == tpsp_pkg::REQ_TICK) |=> !s1_updated_ff)
      else $error("tick item flagged a step update");

   a_low_step : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser == tpsp_pkg::REQ_ADC && below_threshold) |=>
         (sine_step_ff == $past(low_sine_step_ff) && s1_updated_ff))
      else $error("low reading did not load the low sine step");

   a_level_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[18:3] != 16'h8000))
      else $error("carrier level out of range");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted into a full pipeline");

endmodule

// ===== dv/three_phase_sine_pwm_test.sv =====
// Self-checking stream testbench for the three-phase sine PWM block.
module three_phase_sine_pwm_test;
   timeunit 1ns;
   timeprecision 1ps;

   // register index outside the map: a write there must change nothing
   localparam logic [tpsp_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // long receiver hold-off that backs the pipeline up into the request side
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 236;

   // one result item, holding the fields that the block packs
   typedef struct packed {
      logic        leg_a;
      logic        leg_b;
      logic        leg_c;
      logic [15:0] level;
      logic        updated;
   } pwm_result_type;

   // Tracks the PWM state and holds the results still owed by the block.
   class pwm_scoreboard_type;
      localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

      logic [14:0] amp_sine = 15'd29491;
      logic [14:0] amp_carrier = 15'd32767;
      logic [15:0] car_inc = 16'd655;
      logic [31:0] leg_lag = 32'h5555_5555;
      logic [11:0] low_limit = 12'd200;
      logic [31:0] low_inc = 32'd4295;
      logic [15:0] inc_per_count = 16'd21;

      logic [31:0] sin_acc = '0;
      logic [15:0] car_acc = '0;
      logic [31:0] sin_inc = 32'd2147;
      logic [11:0] prev_reading = '0;

      logic [14:0] quarter_wave [256];
      pwm_result_type owed [$];
      int errors = 0;
      int results_seen = 0;

      function new();
         for (int i = 0; i < 256; i++) begin
            quarter_wave[i] = rom_entry(i);
         end
      endfunction

      // quarter-wave sine at the middle of slot i, series in Q30 with truncation
      function logic [14:0] rom_entry(int unsigned i);
         logic [63:0] angle;
         logic [63:0] sq;
         logic [63:0] acc;
         logic [63:0] s;
         logic [63:0] v;
         int unsigned divs [5] = '{110, 72, 42, 20, 6};
         angle = ((64'(i) * 2 + 64'd1) * 64'd1686629713) >> 9;
         sq = (angle * angle) >> 30;
         acc = ONE_Q30;
         foreach (divs[k]) begin
            acc = ONE_Q30 - ((sq * acc) >> 30) / 64'(divs[k]);
         end
         s = (angle * acc) >> 30;
         v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         return (v > 64'd32767) ? 15'h7fff : v[14:0];
      endfunction

      // signed scaled sine at a 32-bit phase
      function int scaled_leg(logic [31:0] ph);
         logic [7:0] slot;
         int mag;
         slot = ph[29:22];
         if (ph[30]) begin
            slot = 8'd255 - slot;
         end
         mag = (int'(quarter_wave[slot]) * int'(amp_sine)) >> 15;
         return ph[31] ? -mag : mag;
      endfunction

      // signed scaled triangle at the current carrier phase
      function int carrier_now();
         int p;
         int wave;
         int mag;
         p = int'(car_acc);
         if (p < 16384) begin
            wave = 2 * p;
         end else if (p < 49152) begin
            wave = 65536 - 2 * p;
         end else begin
            wave = 2 * p - 131072;
         end
         mag = ((wave < 0 ? -wave : wave) * int'(amp_carrier)) >> 15;
         return (wave < 0) ? -mag : mag;
      endfunction

      function void write_reg(logic [tpsp_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] data);
         unique case (idx)
            tpsp_pkg::CSR_SINE_AMPLITUDE:    amp_sine = data[14:0];
            tpsp_pkg::CSR_CARRIER_AMPLITUDE: amp_carrier = data[14:0];
            tpsp_pkg::CSR_CARRIER_STEP:      car_inc = data[15:0];
            tpsp_pkg::CSR_PHASE_SPACING:     leg_lag = data;
            tpsp_pkg::CSR_LOW_ADC_THRESHOLD: low_limit = data[11:0];
            tpsp_pkg::CSR_LOW_SINE_STEP:     low_inc = data;
            tpsp_pkg::CSR_STEP_PER_COUNT:    inc_per_count = data[15:0];
            default: ;
         endcase
      endfunction

      // advance the state for one accepted request and queue what it must produce
      function void note_item(logic kind, logic [11:0] reading);
         pwm_result_type r;
         int lvl;
         int rd;
         int prev;
         r.updated = 1'b0;
         rd = int'(reading);
         prev = int'(prev_reading);
         if (kind == tpsp_pkg::REQ_TICK) begin
            sin_acc = sin_acc + sin_inc;
            car_acc = car_acc + car_inc;
         end else if (reading < low_limit) begin
            sin_inc = low_inc;
            prev_reading = reading;
            r.updated = 1'b1;
         end else if (10 * rd < 9 * prev || 10 * rd > 11 * prev) begin
            sin_inc = 32'(inc_per_count) * 32'(reading);
            prev_reading = reading;
            r.updated = 1'b1;
         end
         lvl = carrier_now();
         r.leg_a = scaled_leg(sin_acc) > lvl;
         r.leg_b = scaled_leg(sin_acc - leg_lag) > lvl;
         r.leg_c = scaled_leg(sin_acc - (leg_lag << 1)) > lvl;
         r.level = 16'(lvl);
         owed.push_back(r);
      endfunction

      task report(string msg);
         if (errors < 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
         errors++;
      endtask

      task check_result(logic [tpsp_pkg::RSP_DATA_W-1:0] d);
         pwm_result_type want;
         if (owed.size() == 0) begin
            report($sformatf("result %0d arrived with nothing owed", results_seen));
         end else begin
            want = owed.pop_front();
            if (d[0] !== want.leg_a)
               report($sformatf("result %0d leg_a_high %b, want %b",
                                results_seen, d[0], want.leg_a));
            if (d[1] !== want.leg_b)
               report($sformatf("result %0d leg_b_high %b, want %b",
                                results_seen, d[1], want.leg_b));
            if (d[2] !== want.leg_c)
               report($sformatf("result %0d leg_c_high %b, want %b",
                                results_seen, d[2], want.leg_c));
            if (d[18:3] !== want.level)
               report($sformatf("result %0d carrier_level %0d, want %0d",
                                results_seen, $signed(d[18:3]), $signed(want.level)));
            if (d[19] !== want.updated)
               report($sformatf("result %0d step_updated %b, want %b",
                                results_seen, d[19], want.updated));
            if (d[tpsp_pkg::RSP_DATA_W-1:20] !== '0)
               report($sformatf("result %0d fill bits %h not zero",
                                results_seen, d[tpsp_pkg::RSP_DATA_W-1:20]));
         end
         results_seen++;
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic                              req_tuser = tpsp_pkg::REQ_TICK;   // req_type
   logic [15:0]                       req_tdata = '0;   // adc_value[11:0], zero fill
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // leg_a_high, leg_b_high, leg_c_high, carrier_level[15:0], step_updated, zero fill
   logic [tpsp_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tpsp_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [tpsp_pkg::CSR_DATA_W-1:0]   csr_data = '0;

   pwm_scoreboard_type sb = new();

   // shared pacing controls: steady drops all idling on both sides,
   // hold_pending asks the receiver for one long hold-off
   bit steady = 1'b0;
   bit hold_pending = 1'b0;
   int stall_count = 0;

   three_phase_sine_pwm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Monitor: sample every handshake at the rising edge, feed the scoreboard,
   // and watch for a hung pipeline.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            sb.note_item(req_tuser, req_tdata[11:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            stall_count = 0;
         end else begin
            stall_count++;
         end
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("three_phase_sine_pwm test failed");
            $finish;
         end
      end
   end

   // Receiver: after any pending long hold-off, draw a wait per result, drop tready for it,
   // then hold tready high until a result item is taken.
   initial begin
      int w;
      while (reset) @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         w = steady ? 0 : $urandom_range(0, 13);
         repeat (w) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // idle the request side for a gap of length n and stop at the next falling edge
   task automatic wait_gap(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
   endtask

   // present one item (called at a falling edge) and hold it until taken
   task automatic offer_item(input logic kind, input logic [11:0] reading);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, reading};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // wait for every owed result, then let the two-stage pipe settle
   task automatic wait_drained();
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tpsp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random upper bits above the register width, which the block must drop
   function automatic logic [31:0] with_noise(input logic [31:0] v, input int w);
      if (w >= 32) begin
         return v;
      end
      return (32'($urandom) << w) | (v & ((32'd1 << w) - 32'd1));
   endfunction

   initial begin
      logic [12:0] plan [$];
      logic [31:0] cfg [7];
      logic        kind;
      logic [11:0] reading;
      int          pick;
      int          span;
      int          lo;
      int          hi;

      // hold reset, then release it for good
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset settings: ticks, low readings (also a
      // repeated one), the reading extremes, both edges of the ten percent
      // band, and the threshold edge.
      plan = '{{tpsp_pkg::REQ_TICK, 12'd0}, {tpsp_pkg::REQ_TICK, 12'hfff},
               {tpsp_pkg::REQ_TICK, 12'd0}, {tpsp_pkg::REQ_ADC, 12'd150},
               {tpsp_pkg::REQ_ADC, 12'd150}, {tpsp_pkg::REQ_ADC, 12'd0},
               {tpsp_pkg::REQ_ADC, 12'd4095}, {tpsp_pkg::REQ_TICK, 12'd0},
               {tpsp_pkg::REQ_ADC, 12'd3700}, {tpsp_pkg::REQ_ADC, 12'd3685},
               {tpsp_pkg::REQ_ADC, 12'd1000}, {tpsp_pkg::REQ_ADC, 12'd900},
               {tpsp_pkg::REQ_ADC, 12'd1100}, {tpsp_pkg::REQ_ADC, 12'd1101},
               {tpsp_pkg::REQ_TICK, 12'd5}, {tpsp_pkg::REQ_ADC, 12'd199},
               {tpsp_pkg::REQ_ADC, 12'd200}, {tpsp_pkg::REQ_TICK, 12'd0},
               {tpsp_pkg::REQ_TICK, 12'd0}, {tpsp_pkg::REQ_ADC, 12'd2730},
               {tpsp_pkg::REQ_TICK, 12'd0}, {tpsp_pkg::REQ_TICK, 12'd0}};
      foreach (plan[i]) begin
         wait_gap($urandom_range(0, 13));
         offer_item(plan[i][12], plan[i][11:0]);
      end

      for (int ph = 1; ph <= PHASES; ph++) begin
         // settle the block before touching any register
         stop_req();
         wait_drained();

         unique case (ph)
            1: cfg = '{32'h7fff, 32'h7fff, 32'hffff, 32'hffff_ffff,
                       32'hfff, 32'hffff_ffff, 32'hffff};
            2: cfg = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
            default: begin
               cfg[0] = ($urandom_range(0, 3) == 0) ? 32'h7fff : $urandom_range(0, 32767);
               cfg[1] = ($urandom_range(0, 3) == 0) ? 32'h7fff : $urandom_range(0, 32767);
               cfg[2] = (ph == 3) ? 32'd32768 : $urandom_range(1, 4096);
               cfg[3] = ($urandom_range(0, 1) == 0) ? 32'h5555_5555 : $urandom;
               cfg[4] = $urandom_range(0, 600);
               cfg[5] = $urandom;
               cfg[6] = $urandom_range(0, 65535);
            end
         endcase
         write_csr(tpsp_pkg::CSR_SINE_AMPLITUDE,    with_noise(cfg[0], 15));
         write_csr(tpsp_pkg::CSR_CARRIER_AMPLITUDE, with_noise(cfg[1], 15));
         write_csr(tpsp_pkg::CSR_CARRIER_STEP,      with_noise(cfg[2], 16));
         write_csr(tpsp_pkg::CSR_PHASE_SPACING,     cfg[3]);
         write_csr(tpsp_pkg::CSR_LOW_ADC_THRESHOLD, with_noise(cfg[4], 12));
         write_csr(tpsp_pkg::CSR_LOW_SINE_STEP,     cfg[5]);
         write_csr(tpsp_pkg::CSR_STEP_PER_COUNT,    with_noise(cfg[6], 16));
         write_csr(CSR_UNMAPPED,                    $urandom);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // every third stretch of 40 items runs with no idling
            steady = ((n / 40) % 3 == 1);
            if (ph == 3 && n == 40) begin
               hold_pending = 1'b1;
            end
            if (ph == 5 && n == 120) begin
               stop_req();
               wait_drained();
            end
            wait_gap(steady ? 0 : $urandom_range(0, 13));

            // mostly ticks; readings near the last accepted one, at or below the
            // threshold, or anywhere
            if ($urandom_range(0, 99) < 72) begin
               kind = tpsp_pkg::REQ_TICK;
               reading = 12'($urandom);
            end else begin
               kind = tpsp_pkg::REQ_ADC;
               pick = $urandom_range(0, 9);
               if (pick < 4) begin
                  span = int'(sb.prev_reading) / 6 + 2;
                  lo = int'(sb.prev_reading) - span;
                  hi = int'(sb.prev_reading) + span;
                  lo = (lo < 0) ? 0 : lo;
                  hi = (hi > 4095) ? 4095 : hi;
                  reading = 12'($urandom_range(lo, hi));
               end else if (pick < 7) begin
                  reading = 12'($urandom_range(0, int'(sb.low_limit)));
               end else begin
                  reading = 12'($urandom);
               end
            end
            offer_item(kind, reading);
         end
      end

      steady = 1'b0;
      stop_req();
      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.owed.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.owed.size()));
      end
      if (sb.errors == 0) begin
         $display("three_phase_sine_pwm test passed");
      end else begin
         $display("three_phase_sine_pwm test failed");
      end
      $finish;
   end

endmodule
